>>> src/tnd_pkg.sv
// shared constants, types and codes of the tanh neuron block
package tnd_pkg;

  // data formats
  localparam int DATA_W       = 16;
  localparam int ACT_W        = 14;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = 40;
  localparam int FRAC_BITS    = 12;

  // exp evaluation: polynomial on a small argument, then repeated squaring
  localparam int SPREAD_SHIFT = 21;
  localparam int SQ_STEPS     = SPREAD_SHIFT - FRAC_BITS;
  localparam int Y_SHIFT      = 32 - SPREAD_SHIFT;
  localparam int MAG_W        = DATA_W + 1;
  localparam int Y_W          = MAG_W + Y_SHIFT;
  localparam int Q31_W        = 32;
  localparam int DEN_W        = Q31_W + 1;

  // divide by three as multiply by reciprocal, exact for 16-bit operands
  localparam int RECIP3       = 43691;
  localparam int RECIP3_SH    = 17;

  // final restoring division
  localparam int QUO_W        = FRAC_BITS + 1;
  localparam int DVD_W        = Q31_W + FRAC_BITS;
  localparam int RES_W        = (QUO_W + 1 > ACT_W) ? QUO_W + 1 : ACT_W;
  localparam int CNT_W        = 4;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAC,
    ST_PRE,
    ST_ABS,
    ST_MY2,
    ST_WY2,
    ST_MY3,
    ST_WY3,
    ST_MY4,
    ST_WY4,
    ST_DIV3,
    ST_POLY,
    ST_SQM,
    ST_SQW,
    ST_DPREP,
    ST_DINIT,
    ST_DSTEP,
    ST_FIN
  } state_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAC,
    OP_PRE,
    OP_ABS,
    OP_MUL_Y2,
    OP_WR_Y2,
    OP_MUL_Y3,
    OP_WR_Y3,
    OP_MUL_Y4,
    OP_WR_Y4,
    OP_DIV3,
    OP_POLY,
    OP_MUL_SQ,
    OP_WR_SQ,
    OP_DPREP,
    OP_DINIT,
    OP_DSTEP,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } stat_t;

endpackage

>>> src/tnd_if.sv
// item channel interfaces of the tanh neuron block

// input item channel
interface tnd_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   x_value;
  logic signed [15:0]   weight;
  logic                 last;

  modport source (output valid, output x_value, output weight, output last, input ready);
  modport sink   (input valid, input x_value, input weight, input last, output ready);
endinterface

// result item channel
interface tnd_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [13:0]   activation;

  modport source (output valid, output activation, input ready);
  modport sink   (input valid, input activation, output ready);
endinterface

>>> src/tnd_datapath.sv
// datapath: multiply-accumulate, bias and clamp, exp polynomial, squaring, divider
module tnd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic signed [15:0]             cfg_wdata_i,
  input  logic signed [15:0]             x_value_i,
  input  logic signed [15:0]             weight_i,
  input  tnd_pkg::cmd_t                  cmd_i,
  output tnd_pkg::stat_t                 stat_o,
  output logic signed [13:0]             activation_o
);
  import tnd_pkg::*;

  localparam int SUM_W = ACC_W + 1;
  localparam int PRE_W = ACC_W + 2;
  localparam int REM_W = DEN_W;

  localparam logic signed [ACC_W-1:0] AccMax = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] AccMin = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [Q31_W-1:0]        Q31One = Q31_W'(64'd1 << 31);

  logic signed [15:0]        bias_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [DATA_W-1:0]  s_q, s_d;
  logic                      sign_q;
  logic [Y_W-1:0]            y_q;
  logic [63:0]               p_q;
  logic [Q31_W-1:0]          rnd;
  logic [21:0]               y2_q;
  logic [16:0]               y3_q;
  logic [11:0]               y4_q;
  logic [15:0]               q3a_q, q3b_q;
  logic [Q31_W-1:0]          e_q, e_d;
  logic [DEN_W-1:0]          den_q;
  logic [DVD_W-1:0]          num_q, dvd;
  logic [REM_W-1:0]          rem_q;
  logic [QUO_W-1:0]          dlo_q, quo_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [13:0]        act_q;
  logic [31:0]               mul_a, mul_b;
  logic signed [SUM_W-1:0]   mac_sum;
  logic signed [PRE_W-1:0]   pre_sum, pre_sh;
  logic [MAG_W-1:0]          s_ext, t_mag;
  logic [32:0]               q3a_p, q3b_p;
  logic [Q31_W:0]            poly;
  logic [REM_W:0]            trial;
  logic                      trial_ge;
  logic [RES_W-1:0]          res_mag, res_val;

  // bias register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  // product of the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      prod_q <= x_value_i * weight_i;
    end
  end

  // saturating accumulate
  assign mac_sum = {acc_q[ACC_W-1], acc_q} + SUM_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.op == OP_MAC) begin
      if (mac_sum[SUM_W-1] != mac_sum[SUM_W-2]) begin
        acc_d = mac_sum[SUM_W-1] ? AccMin : AccMax;
      end else begin
        acc_d = mac_sum[ACC_W-1:0];
      end
    end else if (cmd_i.op == OP_PRE) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // bias, round to nearest and clamp to the data range
  assign pre_sum = PRE_W'(acc_q) + (PRE_W'(bias_q) <<< FRAC_BITS)
                 + PRE_W'(64'd1 << (FRAC_BITS - 1));
  assign pre_sh  = pre_sum >>> FRAC_BITS;

  always_comb begin
    if (pre_sh > PRE_W'(32767)) begin
      s_d = 16'sh7fff;
    end else if (pre_sh < -PRE_W'(32768)) begin
      s_d = -16'sh8000;
    end else begin
      s_d = pre_sh[DATA_W-1:0];
    end
  end

  // magnitude of the sum
  assign s_ext = MAG_W'(s_q);
  assign t_mag = s_q[DATA_W-1] ? (~s_ext + MAG_W'(1)) : s_ext;

  // shared multiplier with registered product
  always_comb begin
    mul_a = 32'(y_q);
    mul_b = 32'(y_q);
    case (cmd_i.op)
      OP_MUL_Y3: mul_a = 32'(y2_q);
      OP_MUL_Y4: mul_a = 32'(y3_q);
      OP_MUL_SQ: begin
        mul_a = e_q;
        mul_b = e_q;
      end
      default: mul_a = 32'(y_q);
    endcase
  end

  assign rnd = Q31_W'((p_q + 64'(64'd1 << 30)) >> 31);

  // divisions by six and twenty-four through the reciprocal of three
  assign q3a_p = (33'(y3_q >> 1) * 33'(RECIP3)) >> RECIP3_SH;
  assign q3b_p = (33'(y4_q >> 3) * 33'(RECIP3)) >> RECIP3_SH;

  // taylor polynomial of exp(-y)
  assign poly = 33'(Q31One) + 33'(y2_q >> 1) + 33'(q3b_q) - 33'(y_q) - 33'(q3a_q);

  always_comb begin
    e_d = e_q;
    if (cmd_i.op == OP_POLY) begin
      e_d = poly[Q31_W-1:0];
    end else if (cmd_i.op == OP_WR_SQ) begin
      e_d = rnd;
    end
  end

  // dividend with half the divisor added for rounding
  assign dvd = num_q + DVD_W'(den_q >> 1);

  // one restoring division step
  assign trial    = {rem_q, dlo_q[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, den_q};

  // signed result
  assign res_mag = {{(RES_W-QUO_W){1'b0}}, quo_q};
  assign res_val = sign_q ? (~res_mag + RES_W'(1)) : res_mag;

  // tanh evaluation registers
  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    case (cmd_i.op)
      OP_PRE: s_q <= s_d;
      OP_ABS: begin
        sign_q <= s_q[DATA_W-1];
        y_q    <= Y_W'(t_mag) << Y_SHIFT;
      end
      OP_MUL_Y2, OP_MUL_Y3, OP_MUL_Y4, OP_MUL_SQ: p_q <= mul_a * mul_b;
      OP_WR_Y2: y2_q <= rnd[21:0];
      OP_WR_Y3: y3_q <= rnd[16:0];
      OP_WR_Y4: y4_q <= rnd[11:0];
      OP_DIV3: begin
        q3a_q <= q3a_p[15:0];
        q3b_q <= q3b_p[15:0];
      end
      OP_DPREP: begin
        den_q <= DEN_W'(Q31One) + DEN_W'(e_q);
        num_q <= DVD_W'(Q31One - e_q) << FRAC_BITS;
      end
      OP_DINIT: begin
        rem_q <= REM_W'(dvd[DVD_W-1:QUO_W]);
        dlo_q <= dvd[QUO_W-1:0];
        quo_q <= '0;
      end
      OP_DSTEP: begin
        rem_q <= trial_ge ? REM_W'(trial - {1'b0, den_q}) : trial[REM_W-1:0];
        dlo_q <= dlo_q << 1;
        quo_q <= {quo_q[QUO_W-2:0], trial_ge};
      end
      OP_RESULT: act_q <= res_val[ACT_W-1:0];
      default: ;
    endcase
  end

  // step counter for the squaring and division loops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_POLY:  cnt_q <= CNT_W'(SQ_STEPS - 1);
        OP_DINIT: cnt_q <= CNT_W'(QUO_W - 1);
        OP_WR_SQ, OP_DSTEP: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign activation_o    = act_q;

endmodule

>>> src/tnd_ctrl.sv
// controller: sequences accumulation, tanh evaluation and result handoff
module tnd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tnd_pkg::cmd_t   cmd_o,
  input  tnd_pkg::stat_t  stat_i
);
  import tnd_pkg::*;

  state_e state_q, state_d;
  logic   last_q;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MAC;
      ST_MAC:   state_d = last_q ? ST_PRE : ST_IDLE;
      ST_PRE:   state_d = ST_ABS;
      ST_ABS:   state_d = ST_MY2;
      ST_MY2:   state_d = ST_WY2;
      ST_WY2:   state_d = ST_MY3;
      ST_MY3:   state_d = ST_WY3;
      ST_WY3:   state_d = ST_MY4;
      ST_MY4:   state_d = ST_WY4;
      ST_WY4:   state_d = ST_DIV3;
      ST_DIV3:  state_d = ST_POLY;
      ST_POLY:  state_d = ST_SQM;
      ST_SQM:   state_d = ST_SQW;
      ST_SQW:   state_d = stat_i.cnt_zero ? ST_DPREP : ST_SQM;
      ST_DPREP: state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DSTEP;
      ST_DSTEP: if (stat_i.cnt_zero) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE:  cmd_o.op = in_acc ? OP_LOAD : OP_NONE;
      ST_MAC:   cmd_o.op = OP_MAC;
      ST_PRE:   cmd_o.op = OP_PRE;
      ST_ABS:   cmd_o.op = OP_ABS;
      ST_MY2:   cmd_o.op = OP_MUL_Y2;
      ST_WY2:   cmd_o.op = OP_WR_Y2;
      ST_MY3:   cmd_o.op = OP_MUL_Y3;
      ST_WY3:   cmd_o.op = OP_WR_Y3;
      ST_MY4:   cmd_o.op = OP_MUL_Y4;
      ST_WY4:   cmd_o.op = OP_WR_Y4;
      ST_DIV3:  cmd_o.op = OP_DIV3;
      ST_POLY:  cmd_o.op = OP_POLY;
      ST_SQM:   cmd_o.op = OP_MUL_SQ;
      ST_SQW:   cmd_o.op = OP_WR_SQ;
      ST_DPREP: cmd_o.op = OP_DPREP;
      ST_DINIT: cmd_o.op = OP_DINIT;
      ST_DSTEP: cmd_o.op = OP_DSTEP;
      ST_FIN:   cmd_o.op = out_free ? OP_RESULT : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        last_q <= in_last_i;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/tanh_neuron_dot_product.sv
// top level: tanh neuron forward pass, controller plus datapath
// an item that is not last is multiplied, then added by the saturating accumulate
// a last item then runs through bias, clamp and exp polynomial, the nine squarings
// on the shared multiplier and the 13-step divider to the result
// the next item is taken once the controller is back in idle; a pending result waits
// in the output register; reset clears bias, accumulator, state and result valid
module tanh_neuron_dot_product (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i,
  tnd_in_if.sink             in_i,
  tnd_out_if.source          out_o
);
  import tnd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  tnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic
  tnd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .x_value_i    (in_i.x_value),
    .weight_i     (in_i.weight),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .activation_o (out_o.activation)
  );

endmodule
